@@ design/swhsr_pkg.sv @@
// Shared types and constants for the single-wire humidity sensor reader.
// No dependencies; every other design file imports this package.
package swhsr_pkg;

    // Width of the saturating tick counter (valid range 12 to 24).
    localparam int CNT_W = 16;
    // Compare width that covers both the counter and the 16-bit start time.
    localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam int FRAME_W = 40;
    localparam logic [5:0] FRAME_BITS = 6'd40;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_KIND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD = 3'd4;

    localparam logic        RST_SENSOR_KIND   = 1'b0;
    localparam logic [15:0] RST_START_LOW     = 16'd18000;
    localparam logic [7:0]  RST_RELEASE       = 8'd30;
    localparam logic [9:0]  RST_TIMEOUT       = 10'd120;
    localparam logic [7:0]  RST_ONE_THRESHOLD = 8'd50;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_RELEASE   = 3'd2,
        PH_RESP_LOW  = 3'd3,
        PH_RESP_HIGH = 3'd4,
        PH_RESP_LOW2 = 3'd5,
        PH_BIT_HIGH  = 3'd6,
        PH_MEASURE   = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_CHECKSUM = 2'd2
    } t_status;

    typedef struct packed {
        logic cmd;
        logic line_level;
    } t_in_item;

    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        t_status            status;
        logic [15:0]        humidity_tenths;
        logic signed [15:0] temperature_tenths;
    } t_out_item;

    // Decoded frame handed from the frame decoder to the sequencer.
    typedef struct packed {
        logic               sum_ok;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
    } t_frame_dec;

endpackage

@@ design/swhsr_frame_decode.sv @@
// Frame decoder: checksum test and conversion of a 40-bit sensor frame to tenths.
// Depends on swhsr_pkg.
module swhsr_frame_decode (
    input  logic [swhsr_pkg::FRAME_W-1:0] i_frame,
    input  logic                          i_sensor_kind,
    output swhsr_pkg::t_frame_dec         o_dec
);
    import swhsr_pkg::*;

    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  sum8;
    logic [14:0] mag;

    assign b0 = i_frame[39:32];
    assign b1 = i_frame[31:24];
    assign b2 = i_frame[23:16];
    assign b3 = i_frame[15:8];
    assign b4 = i_frame[7:0];

    assign sum8 = b0 + b1 + b2 + b3;
    assign mag  = {b2[6:0], b3};

    always_comb begin
        o_dec.sum_ok = (sum8 == b4);
        if (i_sensor_kind) begin
            // sign-magnitude words; negative zero folds to zero
            o_dec.humidity    = {b0, b1};
            o_dec.temperature = b2[7] ? (16'sd0 - $signed({1'b0, mag}))
                                      : $signed({1'b0, mag});
        end else begin
            // integer byte times ten plus tenths byte
            o_dec.humidity    = ({8'd0, b0} << 3) + ({8'd0, b0} << 1) + {8'd0, b1};
            o_dec.temperature = $signed(({8'd0, b2} << 3) + ({8'd0, b2} << 1)
                                        + {8'd0, b3});
        end
    end

endmodule

@@ design/single_wire_humidity_sensor_reader.sv @@
// Top level of the single-wire humidity/temperature sensor reader.
// Depends on swhsr_pkg and swhsr_frame_decode.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------
//   input   | in        | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//   result  | out       | o_out_valid / i_out_stall| o_out_item (t_out_item)
//   config  | in        | i_cfg_we (no wait)      | i_cfg_index, i_cfg_data
//
// Each item (one microsecond tick or a start command) passes through the input
// register and then the result register, one item per cycle sustained while
// the result is not stalled. The sequencer state update for an item is the
// single pass between those two registers.
// Synchronous active-low reset returns the sequencer to idle, clears held
// readings and loads the default timing registers.
// A stalled result holds the result register; the input register then holds
// its item and o_in_stall rises until the result register frees.
module single_wire_humidity_sensor_reader (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // item input
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  swhsr_pkg::t_in_item                    i_in_item,
    // result output
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output swhsr_pkg::t_out_item                   o_out_item,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [swhsr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [swhsr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import swhsr_pkg::*;

    // configuration registers
    logic        r_sensor_kind;
    logic [15:0] r_start_low;
    logic [7:0]  r_release;
    logic [9:0]  r_timeout;
    logic [7:0]  r_one_thr;

    // pipeline registers
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    // sequencer state
    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [5:0]         r_bits, n_bits;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [15:0]        r_hum, n_hum;
    logic signed [15:0] r_temp, n_temp;

    logic               adv;
    logic               step;
    logic [CNT_W-1:0]   cnt_inc;
    logic               want;
    logic               one_bit;
    logic [FRAME_W-1:0] frame_shifted;
    logic               done;
    t_status            status;
    t_frame_dec         dec;

    // Advance the pipeline whenever the result register is free or being taken.
    assign adv        = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // saturating tick increment
    assign cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign want    = (r_phase == PH_RESP_HIGH) || (r_phase == PH_BIT_HIGH);
    assign one_bit = CMP_W'(r_cnt) >= CMP_W'(r_one_thr);

    // frame with the bit of the pulse ending now shifted in, msb first
    assign frame_shifted = {r_frame[FRAME_W-2:0], one_bit};

    swhsr_frame_decode u_decode (
        .i_frame       (frame_shifted),
        .i_sensor_kind (r_sensor_kind),
        .o_dec         (dec)
    );

    // Sequencer: next state for the item sitting in the input register.
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_bits  = r_bits;
        n_frame = r_frame;
        n_hum   = r_hum;
        n_temp  = r_temp;
        done    = 1'b0;
        status  = ST_OK;

        case (r_phase)
            PH_IDLE: begin
                if (r_in_item.cmd) begin
                    n_phase = PH_START;
                    n_cnt   = '0;
                    n_bits  = '0;
                    n_frame = '0;
                end
            end
            PH_START: begin
                // hold the wire low until the start time has passed
                n_cnt = cnt_inc;
                if (CMP_W'(cnt_inc) >= CMP_W'(r_start_low) || cnt_inc == CNT_MAX) begin
                    n_cnt   = '0;
                    n_phase = (r_release == 8'd0) ? PH_RESP_LOW : PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                n_cnt = cnt_inc;
                if (CMP_W'(cnt_inc) >= CMP_W'(r_release) || cnt_inc == CNT_MAX) begin
                    n_cnt   = '0;
                    n_phase = PH_RESP_LOW;
                end
            end
            PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_LOW2, PH_BIT_HIGH: begin
                if (r_in_item.line_level == want) begin
                    n_cnt = '0;
                    case (r_phase)
                        PH_RESP_LOW:  n_phase = PH_RESP_HIGH;
                        PH_RESP_HIGH: n_phase = PH_RESP_LOW2;
                        PH_RESP_LOW2: n_phase = PH_BIT_HIGH;
                        default:      n_phase = PH_MEASURE;
                    endcase
                end else begin
                    n_cnt = cnt_inc;
                    if (CMP_W'(cnt_inc) > CMP_W'(r_timeout)) begin
                        n_phase = PH_IDLE;
                        n_cnt   = '0;
                        done    = 1'b1;
                        status  = ST_TIMEOUT;
                    end
                end
            end
            PH_MEASURE: begin
                if (r_in_item.line_level) begin
                    n_cnt = cnt_inc;
                    if (CMP_W'(cnt_inc) > CMP_W'(r_timeout)) begin
                        n_phase = PH_IDLE;
                        n_cnt   = '0;
                        done    = 1'b1;
                        status  = ST_TIMEOUT;
                    end
                end else begin
                    // falling edge ends the pulse: shift the bit in, msb first
                    n_frame = frame_shifted;
                    n_bits  = r_bits + 1'b1;
                    n_cnt   = '0;
                    if (n_bits >= FRAME_BITS) begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                        if (dec.sum_ok) begin
                            n_hum  = dec.humidity;
                            n_temp = dec.temperature;
                        end else begin
                            status = ST_CHECKSUM;
                        end
                    end else begin
                        n_phase = PH_BIT_HIGH;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // configuration registers; a write lands at once, also in the middle of a read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_kind <= RST_SENSOR_KIND;
            r_start_low   <= RST_START_LOW;
            r_release     <= RST_RELEASE;
            r_timeout     <= RST_TIMEOUT;
            r_one_thr     <= RST_ONE_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SENSOR_KIND:   r_sensor_kind <= i_cfg_data[0];
                CFG_START_LOW:     r_start_low   <= i_cfg_data[15:0];
                CFG_RELEASE:       r_release     <= i_cfg_data[7:0];
                CFG_TIMEOUT:       r_timeout     <= i_cfg_data[9:0];
                CFG_ONE_THRESHOLD: r_one_thr     <= i_cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // input register: take a new transfer whenever the current item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((!r_in_valid || adv) && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // sequencer state commits once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_bits  <= '0;
            r_frame <= '0;
            r_hum   <= '0;
            r_temp  <= '0;
        end else if (step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_bits  <= n_bits;
            r_frame <= n_frame;
            r_hum   <= n_hum;
            r_temp  <= n_temp;
        end
    end

    // result register: hold while stalled, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item.drive_low          <= (n_phase == PH_START);
            r_out_item.busy_res           <= (n_phase != PH_IDLE);
            r_out_item.done_res           <= done;
            r_out_item.status             <= status;
            r_out_item.humidity_tenths    <= n_hum;
            r_out_item.temperature_tenths <= n_temp;
        end
    end

endmodule
